// File: design/tfun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle face unit normal: shared definitions
// Field widths, arithmetic widths and operation codes used by the interfaces,
// the root unit and the top level.
// ----------------------------------------------------------------------------
package tfun_pkg;

    localparam int unsigned MAX_VERTICES_DEF = 4096;

    localparam int IDX_W   = 13;
    localparam int COORD_W = 16;
    localparam int VTX_W   = 3 * COORD_W;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int MOP_W   = 18;
    localparam int PROD_W  = 2 * MOP_W;
    localparam int CROSS_W = 35;
    localparam int MAG_W   = 34;
    localparam int HALF_W  = MAG_W / 2;
    localparam int SQ_W    = 68;
    localparam int SUM_W   = 70;
    localparam int QUO_W   = 29;
    localparam int ROOT_W  = 15;
    localparam int NORM_W  = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FACE = 1'b1;

endpackage

// File: design/tfun_in_if.sv
// ----------------------------------------------------------------------------
// Triangle face unit normal: input channel
// Carries one load or face word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tfun_in_if import tfun_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [IDX_W-1:0]          vertex_slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;

    modport source
    (
        output valid, opcode, vertex_slot, coord_x, coord_y, coord_z,
        output corner_a, corner_b, corner_c,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, vertex_slot, coord_x, coord_y, coord_z,
        input  corner_a, corner_b, corner_c,
        output ready
    );
endinterface

// File: design/tfun_out_if.sv
// ----------------------------------------------------------------------------
// Triangle face unit normal: output channel
// Carries one unit normal word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tfun_out_if import tfun_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;

    modport source
    (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );

    modport sink
    (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

// File: design/tfun_root.sv
// ----------------------------------------------------------------------------
// Triangle face unit normal: component root unit
// Computes floor(sqrt(floor(sq * 2^28 / sum))) with a restoring divider of
// one quotient bit per cycle followed by a bit-serial square root.
// ----------------------------------------------------------------------------
module tfun_root import tfun_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   sq,
    input  logic [SUM_W-1:0]  sum,
    output logic              done,
    output logic [ROOT_W-1:0] q
);

    typedef enum logic [2:0]
    {
        R_IDLE = 3'b001,
        R_DIV  = 3'b010,
        R_SQRT = 3'b100
    } rstate_t;

    localparam int CNT_W = $clog2(QUO_W);

    rstate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic               sq0_reg;
    logic               done_reg;

    logic [SUM_W:0]     shifted;
    logic               ge;
    logic [ROOT_W-1:0]  trial;
    logic [2*ROOT_W-1:0] trial_sq;

    always_comb
    begin
        shifted  = {rem_reg, (cnt_reg == CNT_W'(QUO_W - 1)) ? sq0_reg : 1'b0};
        ge       = shifted >= {1'b0, sum};
        trial    = root_reg | (ROOT_W'(1) << cnt_reg);
        trial_sq = trial * trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= R_DIV;
                    end
                end
                R_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= R_SQRT;
                    end
                end
                R_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= R_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            R_IDLE:
            begin
                rem_reg  <= SUM_W'(sq >> 1);
                sq0_reg  <= sq[0];
                cnt_reg  <= CNT_W'(QUO_W - 1);
                quo_reg  <= '0;
                root_reg <= '0;
            end
            R_DIV:
            begin
                rem_reg <= ge ? SUM_W'(shifted - {1'b0, sum}) : SUM_W'(shifted);
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                cnt_reg <= (cnt_reg == '0) ? CNT_W'(ROOT_W - 1) : cnt_reg - 1'b1;
            end
            R_SQRT:
            begin
                if (trial_sq <= {1'b0, quo_reg})
                begin
                    root_reg <= trial;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign q    = root_reg;

endmodule

// File: design/triangle_face_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle face unit normal
// Vertex store with face normal computation in signed Q1.14.
// ----------------------------------------------------------------------------
// The face_in channel takes two kinds of words. A load word (opcode 0) writes
// one vertex into the store and gives no result; a slot of 0 or above
// MAX_VERTICES is ignored. A face word (opcode 1) names three 1-based corners
// and gives one word on normal_out. A face reads its three corners through the
// single read port of the store, forms the cross product and the squares on
// one shared 18x18 multiplier, and for each of the three components runs a
// restoring division and a square root in the root unit. A face whose cross
// product is zero skips the squaring and the roots and is flagged degenerate.
// face_in is ready only between faces, so one face is worked at a time.
// The finished normal sits in an output register; while it waits for the
// receiver, loads and the next face are still taken, and a second finished
// face holds in its last step until the register frees.
// Reset clears the control state and the output valid flag; the vertex store
// itself is not cleared and holds no meaning until written.
// ----------------------------------------------------------------------------
module triangle_face_unit_normal import tfun_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tfun_in_if.sink    face_in,
    tfun_out_if.source normal_out
);

    localparam int AW          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CROSS_STEPS = 12;
    localparam int SQ_STEPS    = 18;

    typedef enum logic [8:0]
    {
        S_IDLE   = 9'b000000001,
        S_READ   = 9'b000000010,
        S_EDGE   = 9'b000000100,
        S_CROSS  = 9'b000001000,
        S_ABS    = 9'b000010000,
        S_SQUARE = 9'b000100000,
        S_RSTART = 9'b001000000,
        S_RWAIT  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [VTX_W-1:0] store_mem [MAX_VERTICES];
    logic [VTX_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    logic [IDX_W-1:0]          corner_reg [3];
    logic [2:0]                cvalid_reg;
    logic [VTX_W-1:0]          vtx_reg [3];
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [2:0]                neg_reg;
    logic                      degen_reg;
    logic [SQ_W-1:0]           sq_reg [3];
    logic [SUM_W-1:0]          sum_reg;
    logic [ROOT_W-1:0]         q_reg [3];
    logic [1:0]                comp_reg;
    logic [4:0]                step_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [NORM_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic                      out_degen_reg;
    logic                      out_valid_reg;

    logic                      accept;
    logic                      load_en;
    logic                      slot_ok;
    logic [3:0]                j;
    logic [1:0]                ea_idx, eb_idx, mac_comp;
    logic [1:0]                part;
    logic                      sub;
    logic signed [MOP_W-1:0]   mul_a, mul_b;
    logic [SQ_W-1:0]           sq_term;
    logic                      root_start;
    logic                      root_done;
    logic [ROOT_W-1:0]         root_q;
    logic                      out_free;
    logic [1:0]                rd_idx;
    logic [1:0]                cap_idx;

    assign accept  = face_in.valid && face_in.ready;
    assign slot_ok = (face_in.vertex_slot != '0)
                     && (32'(face_in.vertex_slot) <= 32'(MAX_VERTICES));
    assign load_en = accept && (face_in.opcode == OP_LOAD) && slot_ok;
    assign face_in.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || normal_out.ready;
    assign j        = step_reg[4:1];
    assign rd_idx   = step_reg[1:0];
    assign cap_idx  = 2'(step_reg[1:0] - 2'd1);
    assign rd_en    = (state_reg == S_READ) && (step_reg < 5'd3);
    assign rd_addr  = AW'(corner_reg[rd_idx] - 13'd1);

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            store_mem[AW'(face_in.vertex_slot - 13'd1)] <=
                {face_in.coord_z, face_in.coord_y, face_in.coord_x};
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb
    begin
        ea_idx   = 2'd0;
        eb_idx   = 2'd0;
        mac_comp = 2'd0;
        sub      = 1'b0;
        part     = 2'd0;
        case (j)
            4'd0: begin ea_idx = 2'd1; eb_idx = 2'd2; mac_comp = 2'd0; part = 2'd0; end
            4'd1: begin ea_idx = 2'd2; eb_idx = 2'd1; mac_comp = 2'd0; part = 2'd1;
                        sub = 1'b1; end
            4'd2: begin ea_idx = 2'd2; eb_idx = 2'd0; mac_comp = 2'd1; part = 2'd2; end
            4'd3: begin ea_idx = 2'd0; eb_idx = 2'd2; mac_comp = 2'd1; part = 2'd0;
                        sub = 1'b1; end
            4'd4: begin ea_idx = 2'd0; eb_idx = 2'd1; mac_comp = 2'd2; part = 2'd1; end
            4'd5: begin ea_idx = 2'd1; eb_idx = 2'd0; mac_comp = 2'd2; part = 2'd2;
                        sub = 1'b1; end
            4'd6: begin mac_comp = 2'd2; part = 2'd0; end
            4'd7: begin mac_comp = 2'd2; part = 2'd1; end
            4'd8: begin mac_comp = 2'd2; part = 2'd2; end
            default: begin mac_comp = 2'd0; end
        endcase
        if (state_reg == S_SQUARE && j < 4'd6)
        begin
            mac_comp = (j < 4'd3) ? 2'd0 : 2'd1;
        end
    end

    always_comb
    begin
        if (state_reg == S_CROSS)
        begin
            mul_a = MOP_W'(e1_reg[ea_idx]);
            mul_b = MOP_W'(e2_reg[eb_idx]);
        end
        else
        begin
            mul_a = $signed({1'b0, (part == 2'd0) ? mag_reg[mac_comp][HALF_W-1:0]
                                                  : mag_reg[mac_comp][MAG_W-1:HALF_W]});
            mul_b = $signed({1'b0, (part == 2'd2) ? mag_reg[mac_comp][MAG_W-1:HALF_W]
                                                  : mag_reg[mac_comp][HALF_W-1:0]});
        end
        case (part)
            2'd0:    sq_term = SQ_W'($unsigned(prod_reg));
            2'd1:    sq_term = SQ_W'($unsigned(prod_reg)) << (HALF_W + 1);
            default: sq_term = SQ_W'($unsigned(prod_reg)) << (2 * HALF_W);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        root_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && face_in.opcode == OP_FACE)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (step_reg == 5'd3)
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                if (step_reg == 5'(CROSS_STEPS - 1))
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                if (n_reg[0] == '0 && n_reg[1] == '0 && n_reg[2] == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (step_reg == 5'(SQ_STEPS - 1))
                begin
                    state_next = S_RSTART;
                end
            end
            S_RSTART:
            begin
                root_start = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (root_done)
                begin
                    state_next = (comp_reg == 2'd2) ? S_FINISH : S_RSTART;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (normal_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= (state_next != state_reg) ? 5'd0 : step_reg + 5'd1;
        case (state_reg)
            S_IDLE:
            begin
                corner_reg[0] <= face_in.corner_a;
                corner_reg[1] <= face_in.corner_b;
                corner_reg[2] <= face_in.corner_c;
                cvalid_reg[0] <= (face_in.corner_a != '0)
                                 && (32'(face_in.corner_a) <= 32'(MAX_VERTICES));
                cvalid_reg[1] <= (face_in.corner_b != '0)
                                 && (32'(face_in.corner_b) <= 32'(MAX_VERTICES));
                cvalid_reg[2] <= (face_in.corner_c != '0)
                                 && (32'(face_in.corner_c) <= 32'(MAX_VERTICES));
            end
            S_READ:
            begin
                if (step_reg != 5'd0)
                begin
                    vtx_reg[cap_idx] <= cvalid_reg[cap_idx] ? rd_data_reg : '0;
                end
            end
            S_EDGE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_reg[k] <= EDGE_W'($signed(vtx_reg[1][k*COORD_W +: COORD_W]))
                               - EDGE_W'($signed(vtx_reg[0][k*COORD_W +: COORD_W]));
                    e2_reg[k] <= EDGE_W'($signed(vtx_reg[2][k*COORD_W +: COORD_W]))
                               - EDGE_W'($signed(vtx_reg[0][k*COORD_W +: COORD_W]));
                    n_reg[k]  <= '0;
                end
            end
            S_CROSS:
            begin
                if (!step_reg[0])
                begin
                    prod_reg <= mul_a * mul_b;
                end
                else if (sub)
                begin
                    n_reg[mac_comp] <= n_reg[mac_comp] - CROSS_W'(prod_reg);
                end
                else
                begin
                    n_reg[mac_comp] <= n_reg[mac_comp] + CROSS_W'(prod_reg);
                end
            end
            S_ABS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= MAG_W'(n_reg[k][CROSS_W-1] ? -n_reg[k] : n_reg[k]);
                    neg_reg[k] <= n_reg[k][CROSS_W-1];
                    sq_reg[k]  <= '0;
                    q_reg[k]   <= '0;
                end
                sum_reg   <= '0;
                comp_reg  <= 2'd0;
                degen_reg <= (n_reg[0] == '0 && n_reg[1] == '0 && n_reg[2] == '0);
            end
            S_SQUARE:
            begin
                if (!step_reg[0])
                begin
                    prod_reg <= mul_a * mul_b;
                end
                else
                begin
                    sq_reg[mac_comp] <= sq_reg[mac_comp] + sq_term;
                    sum_reg          <= sum_reg + SUM_W'(sq_term);
                end
            end
            S_RWAIT:
            begin
                if (root_done)
                begin
                    q_reg[comp_reg] <= root_q;
                    comp_reg        <= comp_reg + 2'd1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_x_reg     <= neg_reg[0] ? -NORM_W'(q_reg[0]) : NORM_W'(q_reg[0]);
                    out_y_reg     <= neg_reg[1] ? -NORM_W'(q_reg[1]) : NORM_W'(q_reg[1]);
                    out_z_reg     <= neg_reg[2] ? -NORM_W'(q_reg[2]) : NORM_W'(q_reg[2]);
                    out_degen_reg <= degen_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    tfun_root u_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .sq    (sq_reg[comp_reg]),
        .sum   (sum_reg),
        .done  (root_done),
        .q     (root_q)
    );

    assign normal_out.valid      = out_valid_reg;
    assign normal_out.normal_x   = out_x_reg;
    assign normal_out.normal_y   = out_y_reg;
    assign normal_out.normal_z   = out_z_reg;
    assign normal_out.degenerate = out_degen_reg;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Triangle face unit normal testbench
// Loads vertices and sends faces through the input channel, predicts each
// unit normal with an exact integer search, and compares every output word
// field by field. Phases vary sender idling, receiver stalls and hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
    import tfun_pkg::*;

    typedef struct packed {
        logic                      opcode;
        logic [IDX_W-1:0]          vertex_slot;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
    } mesh_word_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic                     degen;
    } normal_word_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NVERT = MAX_VERTICES_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tfun_in_if  face_if();
    tfun_out_if norm_if();

    triangle_face_unit_normal dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .face_in    (face_if),
        .normal_out (norm_if)
    );

    always #5 clk = ~clk;

    logic signed [COORD_W-1:0] vtx_x [NVERT];
    logic signed [COORD_W-1:0] vtx_y [NVERT];
    logic signed [COORD_W-1:0] vtx_z [NVERT];
    bit                        vtx_loaded [NVERT];
    int                        loaded_slots [$];
    normal_word_t              normals_due [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  errors = 0;
    int  quiet_cycles = 0;

    initial
    begin
        face_if.valid = 1'b0;
        face_if.opcode = OP_LOAD;
        face_if.vertex_slot = '0;
        face_if.coord_x = '0;
        face_if.coord_y = '0;
        face_if.coord_z = '0;
        face_if.corner_a = '0;
        face_if.corner_b = '0;
        face_if.corner_c = '0;
        norm_if.ready = 1'b0;
    end

    function automatic logic [NORM_W-1:0] unit_component(longint c, logic [127:0] sumsq);
        logic [127:0] mag;
        logic [127:0] target;
        logic [127:0] t;
        logic [127:0] q;
        mag = (c < 0) ? -c : c;
        target = (mag * mag) << 28;
        q = 0;
        for (int b = 14; b >= 0; b--)
        begin
            t = q | (128'd1 << b);
            if (t <= 16384 && sumsq * t * t <= target)
                q = t;
        end
        return (c < 0) ? -q[NORM_W-1:0] : q[NORM_W-1:0];
    endfunction

    function automatic void fetch_vertex(int idx, output longint v[3]);
        if (idx == 0 || idx > NVERT)
        begin
            v[0] = 0; v[1] = 0; v[2] = 0;
        end
        else
        begin
            v[0] = vtx_x[idx-1]; v[1] = vtx_y[idx-1]; v[2] = vtx_z[idx-1];
        end
    endfunction

    function automatic void predict_word(mesh_word_t w);
        longint a[3], b[3], c[3], e1[3], e2[3], n[3];
        logic [127:0] sumsq;
        normal_word_t r;
        if (w.opcode == OP_LOAD)
        begin
            if (w.vertex_slot >= 1 && w.vertex_slot <= NVERT)
            begin
                vtx_x[w.vertex_slot-1] = w.coord_x;
                vtx_y[w.vertex_slot-1] = w.coord_y;
                vtx_z[w.vertex_slot-1] = w.coord_z;
                if (!vtx_loaded[w.vertex_slot-1])
                    loaded_slots.insert(loaded_slots.size(), int'(w.vertex_slot));
                vtx_loaded[w.vertex_slot-1] = 1'b1;
            end
            return;
        end
        fetch_vertex(w.corner_a, a);
        fetch_vertex(w.corner_b, b);
        fetch_vertex(w.corner_c, c);
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
            r.degen = 1'b1;
        else
        begin
            sumsq = 0;
            for (int i = 0; i < 3; i++)
                sumsq += 128'(n[i] < 0 ? -n[i] : n[i]) * 128'(n[i] < 0 ? -n[i] : n[i]);
            r.nx = unit_component(n[0], sumsq);
            r.ny = unit_component(n[1], sumsq);
            r.nz = unit_component(n[2], sumsq);
        end
        normals_due.insert(normals_due.size(), r);
    endfunction

    task automatic send_word(mesh_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            face_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        face_if.valid       <= 1'b1;
        face_if.opcode      <= w.opcode;
        face_if.vertex_slot <= w.vertex_slot;
        face_if.coord_x     <= w.coord_x;
        face_if.coord_y     <= w.coord_y;
        face_if.coord_z     <= w.coord_z;
        face_if.corner_a    <= w.corner_a;
        face_if.corner_b    <= w.corner_b;
        face_if.corner_c    <= w.corner_c;
        @(posedge clk);
        while (!face_if.ready)
            @(posedge clk);
        predict_word(w);
    endtask

    function automatic mesh_word_t rand_fill();
        mesh_word_t   w;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(mesh_word_t)-1:0];
        return w;
    endfunction

    task automatic send_load(int slot, int x, int y, int z);
        mesh_word_t w;
        w = rand_fill();
        w.opcode = OP_LOAD;
        w.vertex_slot = IDX_W'(slot);
        w.coord_x = COORD_W'(x); w.coord_y = COORD_W'(y); w.coord_z = COORD_W'(z);
        send_word(w);
    endtask

    task automatic send_face(int ca, int cb, int cc);
        mesh_word_t w;
        w = rand_fill();
        w.opcode = OP_FACE;
        w.corner_a = IDX_W'(ca); w.corner_b = IDX_W'(cb); w.corner_c = IDX_W'(cc);
        send_word(w);
    endtask

    function automatic int pick_corner();
        int r;
        r = $urandom_range(99);
        if (r < 6 || loaded_slots.size() == 0)
            return (r % 2) ? 0 : $urandom_range(8191, NVERT + 1);
        return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(512) - 256;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    task automatic send_random(int count);
        int a;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 55 || loaded_slots.size() < 3)
            begin
                if ($urandom_range(99) < 4)
                    send_load($urandom_range(8191), pick_coord(), pick_coord(), pick_coord());
                else
                    send_load($urandom_range(NVERT, 1), pick_coord(), pick_coord(),
                              pick_coord());
            end
            else if ($urandom_range(99) < 5)
            begin
                a = pick_corner();
                send_face(a, a, pick_corner());
            end
            else
                send_face(pick_corner(), pick_corner(), pick_corner());
        end
    endtask

    task automatic wait_drained();
        face_if.valid <= 1'b0;
        @(posedge clk);
        while (normals_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_load(1, 0, 0, 0);
        send_load(2, 256, 0, 0);
        send_load(3, 0, 256, 0);
        send_load(NVERT, -32768, -32768, -32768);
        send_load(NVERT - 1, 32767, -32768, 32767);
        send_load(NVERT - 2, -32768, 32767, 32767);
        send_load(0, 1234, 5, 6);
        send_load(NVERT + 1, 7, 8, 9);
        send_load(8191, -1, -1, -1);
        send_face(1, 2, 3);
        send_face(1, 3, 2);
        send_face(2, 2, 3);
        send_face(1, 1, 1);
        send_face(NVERT, NVERT - 1, NVERT - 2);
        send_face(0, NVERT - 1, NVERT - 2);
        send_face(8191, 2, 3);
        send_face(0, 0, 0);
        send_load(4, 512, 512, 0);
        send_face(1, 2, 4);
        send_face(2, 3, NVERT + 1);
        wait_drained();
    endtask

    task automatic test_random_steady();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_random(250);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 69; recv_stall_pct = 0;
        send_random(220);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct = 0; recv_stall_pct = 69;
        send_random(220);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct = 22; recv_stall_pct = 22;
        send_random(220);
    endtask

    task automatic test_receiver_hold_off();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
            send_face(pick_corner(), pick_corner(), pick_corner());
        send_random(40);
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 0; recv_stall_pct = 40;
        send_random(30);
        wait_drained();
        send_random(30);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            norm_if.ready <= 1'b0;
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 900;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                norm_if.ready <= 1'b0;
            end
            else
                norm_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        normal_word_t got;
        normal_word_t want;
        if (rst_n && norm_if.valid && norm_if.ready)
        begin
            got = {norm_if.normal_x, norm_if.normal_y, norm_if.normal_z, norm_if.degenerate};
            if (normals_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected normal word, expected none, actual %p", $time, got);
            end
            else
            begin
                want = normals_due.pop_front();
                if (got.nx !== want.nx)
                begin
                    errors++;
                    $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, got.nx);
                end
                if (got.ny !== want.ny)
                begin
                    errors++;
                    $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, got.ny);
                end
                if (got.nz !== want.nz)
                begin
                    errors++;
                    $display("%0t: normal_z expected %0d actual %0d", $time, want.nz, got.nz);
                end
                if (got.degen !== want.degen)
                begin
                    errors++;
                    $display("%0t: degenerate expected %0b actual %0b", $time, want.degen,
                             got.degen);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((face_if.valid && face_if.ready) || (norm_if.valid && norm_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_steady();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_receiver_hold_off();
        test_sender_pause();
        wait_drained();
        repeat (400) @(posedge clk);
        if (errors == 0 && normals_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: sim.f
design/tfun_pkg.sv
design/tfun_in_if.sv
design/tfun_out_if.sv
design/tfun_root.sv
design/triangle_face_unit_normal.sv
sim/tb_top.sv
